// ===== rtl/core/lgs_pkg.sv =====
// Shared constants, chain control type and the B3/S23 rule for the life generation stream.
`timescale 1ns / 1ps
package lgs_pkg;

	// Default and reset widths of the grid
	localparam int           LGS_MAX_COLS    = 32;
	localparam logic [5:0]   GRID_COLS_RESET = 6'd32;

	// Row position codes
	localparam logic [1:0]   ROW_FIRST  = 2'd0;
	localparam logic [1:0]   ROW_SECOND = 2'd1;
	localparam logic [1:0]   ROW_LATER  = 2'd2;

	// Control broadcast to every cell of the row chain
	typedef struct packed {
		logic adv;      // step taken this cycle: pass the column token on
		logic wr;       // update the selected column
		logic restart;  // access column zero regardless of the token
		logic din;      // new bit for the lower row store
	} chain_ctl_t;

	// Next state of the window center: birth on three, survival on two or three
	function automatic logic life_next(input logic [8:0] win);
		logic [3:0] count;
		count = 4'd0;
		for (int b = 0; b < 9; b++) begin
			if (b != 4) begin
				count = count + {3'd0, win[b]};
			end
		end
		if (win[4]) begin
			life_next = (count == 4'd2) || (count == 4'd3);
		end else begin
			life_next = (count == 4'd3);
		end
	endfunction

endpackage

// ===== rtl/core/life_generation_stream.sv =====
// Top level: streams one Conway B3/S23 generation over a raster-ordered grid.
//
//   channel   direction  handshake                   payload
//   in        sink       in_valid / in_ready         cell_alive, frame_end
//   out       source     out_valid / out_ready       next_alive, frame_last
//   config    sink       grid_cols_we                grid_cols
//
// One cell is taken per cycle while the output register drains; each cell but a
// frame_end cell gives at most one result. A cell marked frame_end starts a flush
// (one column of the cell chain per cycle), during which no input is taken.
// Reset clears control, window and the column token; the row stores are not cleared.
// A stalled output holds the flush and input in place.
`timescale 1ns / 1ps
module life_generation_stream #(
	parameter int MAX_COLS = lgs_pkg::LGS_MAX_COLS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       grid_cols_we,
	input  logic [5:0] grid_cols,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cell_alive,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       next_alive,
	output logic       frame_last
);
	import lgs_pkg::*;

	localparam int         CW        = $clog2(MAX_COLS + 1);
	localparam logic [5:0] MAX_COLS6 = 6'(MAX_COLS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TAIL = 2'd1;
	localparam logic [1:0] ST_HEAD = 2'd2;

	logic [5:0]    grid_cols_q;
	logic [1:0]    state_q;
	logic [CW-1:0] col_q;
	logic [1:0]    row_q;
	logic [CW-1:0] fk_q;
	logic [1:0]    fr_q;
	logic [8:0]    win_q;
	logic          out_valid_q;
	logic          next_alive_q;
	logic          frame_last_q;

	logic [5:0]    w6;
	logic [CW-1:0] w;
	logic          out_free;
	logic          wrap;
	logic [CW-1:0] k;
	logic [1:0]    r;
	logic [1:0]    r_next;
	logic [CW-1:0] acc_col;
	logic          col_ok;
	logic          rd_up;
	logic          rd_mid;
	logic [2:0]    triple;
	logic [8:0]    win_new;
	logic [8:0]    win_emit;
	logic          emit;
	logic          emit_last;
	logic          step;
	logic          head_done;
	chain_ctl_t    ctl;

	// Hold the grid width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= GRID_COLS_RESET;
		end else if (grid_cols_we) begin
			grid_cols_q <= grid_cols;
		end
	end

	// Clamp the width to one..MAX_COLS
	assign w6 = (grid_cols_q == 6'd0) ? 6'd1 :
	            (grid_cols_q > MAX_COLS6) ? MAX_COLS6 : grid_cols_q;
	assign w  = w6[CW-1:0];

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign head_done = (col_q == fk_q + CW'(1));

	// Start a new row early when the width shrank below the column
	always_comb begin
		wrap    = (col_q >= w);
		k       = wrap ? '0 : col_q;
		if (wrap) begin
			r = (row_q == ROW_LATER) ? ROW_LATER : row_q + 2'd1;
		end else begin
			r = row_q;
		end
		r_next  = (r == ROW_LATER) ? ROW_LATER : r + 2'd1;
		acc_col = (state_q == ST_IDLE) ? k : col_q;
		col_ok  = (acc_col < w);
	end

	// Build the incoming column, shift the window and pick the result
	always_comb begin
		triple    = 3'b000;
		win_new   = {win_q[5:0], 3'b000};
		win_emit  = win_new;
		emit      = 1'b0;
		emit_last = 1'b0;
		step      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				step   = in_valid && in_ready;
				triple = {(r == ROW_LATER) & rd_up, (r != ROW_FIRST) & rd_mid, cell_alive};
				if (k == '0) begin
					win_emit = {win_q[5:0], 3'b000};
					win_new  = {6'd0, triple};
					emit     = (r == ROW_LATER);
				end else begin
					win_new  = {win_q[5:0], triple};
					win_emit = win_new;
					emit     = (r != ROW_FIRST);
				end
			end
			ST_TAIL: begin
				step     = out_free;
				triple   = col_ok ? {(fr_q == ROW_LATER) & rd_up, rd_mid, 1'b0} : 3'b000;
				win_new  = {win_q[5:0], triple};
				win_emit = win_new;
				emit     = (fr_q != ROW_FIRST);
			end
			ST_HEAD: begin
				step   = out_free;
				triple = col_ok ? {(fr_q != ROW_FIRST) & rd_up, rd_mid, 1'b0} : 3'b000;
				if (col_q == '0) begin
					win_new = {6'd0, triple};
				end else begin
					win_new = {win_q[5:0], triple};
				end
				win_emit  = win_new;
				emit      = (col_q != '0);
				emit_last = head_done;
			end
			default: begin
				step = 1'b0;
			end
		endcase
	end

	// Drive the cell chain: write on input steps and on in-grid tail steps
	always_comb begin
		ctl.adv     = step;
		ctl.restart = (acc_col == '0);
		ctl.wr      = (state_q == ST_IDLE) || ((state_q == ST_TAIL) && col_ok);
		ctl.din     = (state_q == ST_IDLE) ? cell_alive : 1'b0;
	end

	lgs_chain #(
		.COLS (MAX_COLS)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rd_up  (rd_up),
		.rd_mid (rd_mid)
	);

	// Sequence rows, columns and the frame-end flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= ROW_FIRST;
			fk_q    <= '0;
			fr_q    <= ROW_FIRST;
			win_q   <= '0;
		end else if (step) begin
			case (state_q)
				ST_IDLE: begin
					win_q <= win_new;
					if (frame_end) begin
						fk_q    <= k;
						fr_q    <= r;
						col_q   <= k + CW'(1);
						row_q   <= r;
						state_q <= ST_TAIL;
					end else if (k + CW'(1) >= w) begin
						col_q <= '0;
						row_q <= r_next;
					end else begin
						col_q <= k + CW'(1);
						row_q <= r;
					end
				end
				ST_TAIL: begin
					win_q <= win_new;
					if (col_q == w) begin
						col_q   <= '0;
						state_q <= ST_HEAD;
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				ST_HEAD: begin
					if (head_done) begin
						col_q   <= '0;
						row_q   <= ROW_FIRST;
						win_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						win_q <= win_new;
						col_q <= col_q + CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold a result until its transfer; load the next one on an emitting step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			next_alive_q <= life_next(win_emit);
			frame_last_q <= emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign next_alive = next_alive_q;
	assign frame_last = frame_last_q;

`ifndef SYNTH
	// No input is taken while a flush runs
	a_no_input_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input taken during frame flush");

	// The frame's final result is only loaded as the flush ends
	a_last_ends_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_last_q) |-> (state_q == ST_IDLE))
		else $error("frame_last shown while flush still running");

	// The head sweep never passes the marked column plus one
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HEAD) |-> (col_q <= fk_q + CW'(1)))
		else $error("head sweep ran past the final column");

	// A flush leaves the block at the top of a fresh frame
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HEAD && step && head_done) |=>
		(state_q == ST_IDLE && col_q == '0 && row_q == ROW_FIRST && win_q == '0))
		else $error("frame state not cleared after flush");
`endif

endmodule

// ===== rtl/core/lgs_cell.sv =====
// One grid column: its two row-store bits and its slot of the column token.
`timescale 1ns / 1ps
module lgs_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  lgs_pkg::chain_ctl_t ctl,
	input  logic               head,
	input  logic               sel_prev,
	output logic               sel,
	output logic               rd_up,
	output logic               rd_mid
);
	import lgs_pkg::*;

	logic tok_q;
	logic up_q;
	logic mid_q;

	// Select this column: the head cell on restart, else wherever the token sits
	assign sel    = ctl.restart ? head : tok_q;
	assign rd_up  = sel & up_q;
	assign rd_mid = sel & mid_q;

	// Advance the token from the neighbor on every step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.adv) begin
			tok_q <= sel_prev;
		end
	end

	// Shift the column down one row and take the new lower bit
	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.wr && sel) begin
			up_q  <= mid_q;
			mid_q <= ctl.din;
		end
	end

endmodule

// ===== rtl/core/lgs_chain.sv =====
// Row of column cells holding both row stores, with the read of the selected column.
`timescale 1ns / 1ps
module lgs_chain #(
	parameter int COLS = lgs_pkg::LGS_MAX_COLS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lgs_pkg::chain_ctl_t ctl,
	output logic               rd_up,
	output logic               rd_mid
);
	import lgs_pkg::*;

	logic [COLS-1:0] sel_w;
	logic [COLS-1:0] up_w;
	logic [COLS-1:0] mid_w;

	// Build the chain; the first cell heads it and has no left neighbor
	for (genvar i = 0; i < COLS; i++) begin : g_cell
		logic sel_prev;
		if (i == 0) begin : g_first
			assign sel_prev = 1'b0;
		end else begin : g_next
			assign sel_prev = sel_w[i-1];
		end
		lgs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.head     ((i == 0) ? 1'b1 : 1'b0),
			.sel_prev (sel_prev),
			.sel      (sel_w[i]),
			.rd_up    (up_w[i]),
			.rd_mid   (mid_w[i])
		);
	end

	// Collect the selected column; no column selected reads as dead
	assign rd_up  = |up_w;
	assign rd_mid = |mid_w;

endmodule

// ===== tb/tb_life_generation_stream.sv =====
// Testbench for life_generation_stream: directed and random frames checked against a B3/S23 predictor.
`timescale 1ns / 1ps
module tb_life_generation_stream;
	import lgs_pkg::*;

	localparam int RANDOM_ITEMS  = 45;
	localparam int SETTLE_CYCLES = LGS_MAX_COLS + 8;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic alive;
		logic last;
	} gen_cell_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       grid_cols_we;
	logic [5:0] grid_cols;
	logic       in_valid;
	logic       in_ready;
	logic       cell_alive;
	logic       frame_end;
	logic       out_valid;
	logic       out_ready;
	logic       next_alive;
	logic       frame_last;

	// Predictor state: two stored rows, 3x3 window, position and width
	logic [LGS_MAX_COLS-1:0] prev2_row;
	logic [LGS_MAX_COLS-1:0] prev1_row;
	logic [8:0]              win;
	logic [5:0]              col_q;
	logic [1:0]              row_q;
	logic [5:0]              width_reg;

	gen_cell_t   next_gen_q[$];
	int unsigned mismatch_count = 0;

	bit          use_gaps   = 1'b1;
	int unsigned burst_left = 0;
	logic        rx_hold;
	event        start_hold;

	life_generation_stream DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.grid_cols_we (grid_cols_we),
		.grid_cols    (grid_cols),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cell_alive   (cell_alive),
		.frame_end    (frame_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.next_alive   (next_alive),
		.frame_last   (frame_last)
	);

	always #5 clk = ~clk;

	// Width as the block applies it: zero acts as one, wide values clamp
	function automatic int active_width();
		int w;
		w = width_reg;
		if (w == 0) w = 1;
		if (w > LGS_MAX_COLS) w = LGS_MAX_COLS;
		return w;
	endfunction

	function automatic void shift_window(input logic [2:0] column);
		win = {win[5:0], column};
	endfunction

	// Birth on three neighbors, survival on two or three
	function automatic logic window_rule();
		int count;
		count = 0;
		for (int b = 0; b < 9; b++) begin
			if (b != 4) count += win[b];
		end
		if (win[4]) return (count == 2) || (count == 3);
		return count == 3;
	endfunction

	function automatic void push_next();
		gen_cell_t res;
		res.alive = window_rule();
		res.last  = 1'b0;
		next_gen_q.push_back(res);
	endfunction

	// Work out the results one accepted cell causes
	function automatic void predict_generation(input logic alive, input logic fend);
		int        w;
		int        k;
		bit        later;
		bit        past_first;
		logic [2:0] t;
		gen_cell_t tail;
		w = active_width();
		// start a new row when the width shrank under the position
		if (col_q >= w) begin
			col_q = '0;
			if (row_q != ROW_LATER) row_q = row_q + 2'd1;
		end
		k          = col_q;
		later      = (row_q == ROW_LATER);
		past_first = (row_q != ROW_FIRST);
		if (k == 0) begin
			// close the last column of the row above
			if (later) begin
				shift_window(3'b000);
				push_next();
			end
			win = '0;
		end
		t = {later ? prev2_row[k] : 1'b0, past_first ? prev1_row[k] : 1'b0, alive};
		shift_window(t);
		prev2_row[k] = prev1_row[k];
		prev1_row[k] = alive;
		if (k >= 1 && past_first) push_next();
		if (fend) begin
			// finish the row above the final one
			if (past_first) begin
				for (int c = k + 1; c <= w; c++) begin
					t = 3'b000;
					if (c < w) t = {later ? prev2_row[c] : 1'b0, prev1_row[c], 1'b0};
					shift_window(t);
					push_next();
				end
			end
			for (int c = k + 1; c < w; c++) begin
				prev2_row[c] = prev1_row[c];
				prev1_row[c] = 1'b0;
			end
			// sweep the final, possibly short, row
			win = '0;
			for (int c = 0; c <= k + 1; c++) begin
				t = 3'b000;
				if (c < w) t = {past_first ? prev2_row[c] : 1'b0, prev1_row[c], 1'b0};
				shift_window(t);
				if (c >= 1) push_next();
			end
			if (next_gen_q.size() > 0) begin
				tail      = next_gen_q.pop_back();
				tail.last = 1'b1;
				next_gen_q.push_back(tail);
			end
			win   = '0;
			col_q = '0;
			row_q = ROW_FIRST;
		end else if (k + 1 >= w) begin
			col_q = '0;
			if (row_q != ROW_LATER) row_q = row_q + 2'd1;
		end else begin
			col_q = 6'(k + 1);
		end
	endfunction

	function automatic logic cell_bit(input int density);
		return $urandom_range(0, 99) < density;
	endfunction

	// Offer one cell in bursts with random gaps; leave valid high after the transfer
	task automatic send_cell(input logic alive, input logic fend);
		int unsigned gap;
		if (use_gaps && burst_left == 0) begin
			gap        = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0) burst_left--;
		in_valid   <= 1'b1;
		cell_alive <= alive;
		frame_end  <= fend;
		do @(posedge clk); while (!in_ready);
		predict_generation(alive, fend);
	endtask

	// Drop valid, wait for every expected result, then let the block settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (next_gen_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_width(input logic [5:0] value);
		drain_results();
		grid_cols_we <= 1'b1;
		grid_cols    <= value;
		@(posedge clk);
		grid_cols_we <= 1'b0;
		width_reg = value;
	endtask

	// Two full rows at the reset width, so that every stored entry holds a value
	task automatic test_reset_width();
		for (int i = 0; i < 2 * LGS_MAX_COLS; i++) begin
			send_cell(cell_bit(50), i == 2 * LGS_MAX_COLS - 1);
		end
	endtask

	// Blinker turns from a column into a row; a 2x2 block stays put
	task automatic test_blinker_and_block();
		logic [8:0] blinker;
		blinker = 9'b010_010_010;
		set_width(6'd3);
		for (int i = 0; i < 9; i++) send_cell(blinker[i], i == 8);
		set_width(6'd2);
		for (int i = 0; i < 4; i++) send_cell(1'b1, i == 3);
	endtask

	task automatic test_frame_end_cases();
		set_width(6'd4);
		// frame ends on its very first cell
		send_cell(1'b1, 1'b1);
		// short final row: ends on the second cell of row one
		for (int i = 0; i < 6; i++) send_cell(cell_bit(60), i == 5);
		// frame ends a cell into a later row
		set_width(6'd2);
		for (int i = 0; i < 5; i++) send_cell(i != 2, i == 4);
	endtask

	task automatic test_width_clamp();
		set_width(6'd0);
		for (int i = 0; i < 3; i++) send_cell(1'b1, i == 2);
		set_width(6'd33);
		for (int i = 0; i < LGS_MAX_COLS + 1; i++) send_cell(cell_bit(50), i == LGS_MAX_COLS);
		set_width(6'd63);
		send_cell(1'b0, 1'b1);
	endtask

	// Shrink the width under the position mid-frame, then grow it again
	task automatic test_width_change();
		set_width(6'd4);
		for (int i = 0; i < 6; i++) send_cell(cell_bit(50), 1'b0);
		set_width(6'd2);
		for (int i = 0; i < 3; i++) send_cell(1'b1, 1'b0);
		set_width(6'd6);
		for (int i = 0; i < 6; i++) send_cell(cell_bit(50), i == 5);
	endtask

	// Hold off the receiver while cells keep coming, so the input stalls
	task automatic test_backpressure();
		set_width(6'd8);
		use_gaps = 1'b0;
		-> start_hold;
		for (int i = 0; i < 40; i++) send_cell(cell_bit(50), i == 39);
		use_gaps = 1'b1;
	endtask

	task automatic test_random_frames();
		int sent;
		int w_cfg;
		int w;
		int rows;
		int stop_at;
		int change_at;
		int density;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					w_cfg = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
				end
				1, 2: begin
					w_cfg = $urandom_range(9, 32);
				end
				default: begin
					w_cfg = $urandom_range(1, 8);
				end
			endcase
			set_width(6'(w_cfg));
			w    = active_width();
			rows = (w > 16) ? $urandom_range(1, 2) : $urandom_range(1, 5);
			// end some frames early on a short final row
			if ($urandom_range(0, 3) == 0) begin
				stop_at = (rows - 1) * w + $urandom_range(0, w - 1);
			end else begin
				stop_at = rows * w - 1;
			end
			change_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, stop_at + 1) : -1;
			case ($urandom_range(0, 3))
				0: begin
					density = $urandom_range(0, 1) * 100;
				end
				1: begin
					density = 30;
				end
				default: begin
					density = 50;
				end
			endcase
			use_gaps = ($urandom_range(0, 3) != 0);
			for (int i = 0; i <= stop_at; i++) begin
				if (i == change_at) set_width(6'($urandom_range(1, 8)));
				send_cell(cell_bit(density), i == stop_at);
			end
			sent += stop_at + 1;
		end
		use_gaps = 1'b1;
	endtask

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		gen_cell_t want;
		if (arst_n && out_valid && out_ready) begin
			if (next_gen_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result: next_alive=%0b frame_last=%0b",
						next_alive, frame_last);
				end
			end else begin
				want = next_gen_q.pop_front();
				if (next_alive !== want.alive || frame_last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: expected next_alive=%0b frame_last=%0b, got %0b %0b",
							want.alive, want.last, next_alive, frame_last);
					end
				end
			end
		end
	end

	// Receiver stall pattern, picked at random from a set of modes
	initial begin : receiver
		int unsigned rx_cycle;
		rx_mode_t    rx_mode;
		rx_cycle = 0;
		rx_mode  = RX_FREE;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle % 40 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
			if (rx_hold) begin
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE: begin
						out_ready <= 1'b1;
					end
					RX_COIN: begin
						out_ready <= 1'($urandom_range(0, 1));
					end
					RX_SPARSE: begin
						out_ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						out_ready <= (rx_cycle % 5) < 2;
					end
				endcase
			end
		end
	end

	// Long receiver hold-off, counted here in cycles
	initial begin : hold_off
		rx_hold <= 1'b0;
		forever begin
			@(start_hold);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	initial begin
		#10ms;
		$display("life_generation_stream test failed");
		$finish;
	end

	initial begin
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		cell_alive   <= 1'b0;
		frame_end    <= 1'b0;
		grid_cols_we <= 1'b0;
		grid_cols    <= GRID_COLS_RESET;
		prev2_row = '0;
		prev1_row = '0;
		win       = '0;
		col_q     = '0;
		row_q     = ROW_FIRST;
		width_reg = GRID_COLS_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_width();
		test_blinker_and_block();
		test_frame_end_cases();
		test_width_clamp();
		test_width_change();
		test_backpressure();
		test_random_frames();

		drain_results();
		if (mismatch_count == 0) begin
			$display("life_generation_stream test passed");
		end else begin
			$display("life_generation_stream test failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/lgs_pkg.sv
rtl/core/lgs_cell.sv
rtl/core/lgs_chain.sv
rtl/core/life_generation_stream.sv
tb/tb_life_generation_stream.sv
